[src/baf_pkg.sv]
// Shared types, codes and constants of the barometric/inertial altitude filter.
// Used by the top level and by its port checker; depends on nothing.
package baf_pkg;

    // command codes carried in the input tuser
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_UPDATE = 2'd2;

    // status codes carried in the output tuser
    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_IGNORED = 2'd1;
    localparam logic [1:0] STAT_FEW     = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_GROUND   = 3'd0;
    localparam logic [2:0] CFG_GRAVITY  = 3'd1;
    localparam logic [2:0] CFG_WEIGHT   = 3'd2;
    localparam logic [2:0] CFG_GATE     = 3'd3;
    localparam logic [2:0] CFG_GAIN     = 3'd4;
    localparam logic [2:0] CFG_MIN_SMPL = 3'd5;

    // barometric formula constants
    localparam longint ALT_SCALE_MM  = 44330000;
    localparam longint EXPONENT_Q30  = 204327593;
    localparam int     ROOT_COUNT    = 24;
    localparam int     PRESSURE_SPAN = 131072;
    localparam int     ONE_G_SHIFT   = 12;

    // serial unit lengths
    localparam int MUL_STEPS = 17;
    localparam int DIV_STEPS = 48;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ACC_W,
        ST_VEL_W,
        ST_PRED_W,
        ST_PA_DIV_W,
        ST_PA_H0,
        ST_PA_H1,
        ST_PA_MUL_W,
        ST_PA_Q_W,
        ST_BL_W0,
        ST_BL_W1,
        ST_GATE,
        ST_GAIN_W0,
        ST_GAIN_W1,
        ST_CAL_MUL_W,
        ST_CAL_DIV_W,
        ST_DONE
    } t_state;

    // saturate a signed value to a two's complement range of the given width
    function automatic logic signed [63:0] f_sat(input logic signed [63:0] x,
                                                 input int unsigned bits);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< (bits - 1);
        if (x > lim - 64'sd1) return lim - 64'sd1;
        if (x < -lim) return -lim;
        return x;
    endfunction

endpackage

[src/baro_inertial_altitude_filter.sv]
// Barometric/inertial complementary altitude filter, top level.
// Holds the sequencer, the bit-serial multiplier and divider and the altitude table.
// Depends on baf_pkg.
//
// An update with pressure makes two table lookups, each a 48-step division, a
// 17-step multiply and a second 48-step division. The multiplier works one
// multiplier bit a cycle and the divider one quotient bit a cycle.
// One item is in work at a time; the next is taken once the result sits in the
// output register. Reset is synchronous, active low: state and calibration clear,
// registers return to their defaults, the table is a constant and needs no fill.
module baro_inertial_altitude_filter #(
    parameter int TABLE_ENTRIES = 64,
    parameter int FRACTION_BITS = 16,
    parameter int SEA_LEVEL_PA  = 101325
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: accel_z[15:0], accel_valid[16], pressure[33:17], pressure_valid[34],
    //        time_step[50:35], zero fill[55:51]
    input  logic [55:0]  s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]   s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: altitude_mm[31:0], velocity_mm_s[63:32], bias_mm_s2[84:64],
    //        baro_altitude_mm[116:85], zero fill[119:117]
    output logic [119:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]   m_axis_tuser,
    // configuration writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [19:0]  i_cfg_data
);

    localparam int TABLE_STEP = (baf_pkg::PRESSURE_SPAN + TABLE_ENTRIES - 1) / TABLE_ENTRIES;
    localparam int IDX_W      = $clog2(TABLE_ENTRIES + 1);
    // scale from Q12 counts to the state's fraction bits
    localparam int ACC_UP = (FRACTION_BITS >= baf_pkg::ONE_G_SHIFT) ?
                            FRACTION_BITS - baf_pkg::ONE_G_SHIFT : 0;
    localparam int ACC_DN = (FRACTION_BITS >= baf_pkg::ONE_G_SHIFT) ?
                            0 : baf_pkg::ONE_G_SHIFT - FRACTION_BITS;
    // scale from 16 fraction bits to the state's fraction bits
    localparam int Q_UP = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
    localparam int Q_DN = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;

    typedef logic signed [26:0]   t_tab   [TABLE_ENTRIES + 1];
    typedef longint unsigned      t_roots [baf_pkg::ROOT_COUNT + 1];

    // ---------------------------------------------------------------------
    // Altitude table, built at elaboration from the barometric formula
    // ---------------------------------------------------------------------
    function automatic longint f_log2_q24(input longint unsigned p);
        int              n;
        int              j;
        int              k;
        longint unsigned m;
        longint          fr;
        n = 0;
        for (j = 0; j < 31; j++) begin
            if ((p >> (n + 1)) != 0) n++;
        end
        m  = (p << (30 - n)) & 64'h0000_0000_FFFF_FFFF;
        fr = 0;
        for (k = 0; k < 24; k++) begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (64'd1 << 31)) begin
                m  = m >> 1;
                fr = fr | 64'sd1;
            end
        end
        return longint'(n) * (64'sd1 <<< 24) + fr;
    endfunction

    function automatic longint unsigned f_isqrt(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bt;
        int              j;
        v   = v_in;
        res = 0;
        bt  = 64'd1 << 62;
        for (j = 0; j < 32; j++) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned f_pow(input longint unsigned p, input t_roots rt);
        longint          d;
        longint          e;
        longint          n;
        longint unsigned f;
        longint unsigned r;
        int              i;
        d = f_log2_q24(p) - f_log2_q24(longint'(SEA_LEVEL_PA));
        e = (d * baf_pkg::EXPONENT_Q30) >>> 30;
        n = e >>> 24;
        f = longint'(e - n * (64'sd1 <<< 24));
        r = 64'd1 << 30;
        for (i = 1; i <= baf_pkg::ROOT_COUNT; i++) begin
            if (((f >> (24 - i)) & 64'd1) != 0) r = (r * rt[i]) >> 30;
        end
        if (n > 0) r = r << ((n > 4) ? 4 : n);
        else if (n < 0) r = (-n >= 63) ? 64'd0 : (r >> (-n));
        return r;
    endfunction

    function automatic t_tab f_build();
        t_tab            tab;
        t_roots          rt;
        longint unsigned p;
        longint          v;
        int              i;
        rt[0] = 64'd1 << 31;
        rt[1] = f_isqrt(64'd1 << 61);
        for (i = 2; i <= baf_pkg::ROOT_COUNT; i++) rt[i] = f_isqrt(rt[i - 1] << 30);
        for (i = 0; i <= TABLE_ENTRIES; i++) begin
            p = longint'(i) * longint'(TABLE_STEP);
            if (p == 0) v = baf_pkg::ALT_SCALE_MM;
            else v = baf_pkg::ALT_SCALE_MM -
                     longint'((longint'(baf_pkg::ALT_SCALE_MM) * f_pow(p, rt)) >> 30);
            tab[i] = 27'(v);
        end
        return tab;
    endfunction

    localparam t_tab ALT_TAB = f_build();

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    baf_pkg::t_state r_state, n_state;

    logic [16:0] r_ground;
    logic [13:0] r_grav;
    logic [15:0] r_wgt;
    logic [19:0] r_gate;
    logic [15:0] r_gain;
    logic [15:0] r_mins;

    logic signed [47:0] r_alt, r_vel, r_sum;
    logic signed [39:0] r_bias;
    logic signed [31:0] r_baro;
    logic        [15:0] r_count;

    logic        [1:0]  r_cmd;
    logic signed [15:0] r_accel;
    logic               r_aok;
    logic        [16:0] r_pres;
    logic               r_pok;
    logic        [15:0] r_dt;

    logic signed [44:0] r_corr;
    logic signed [47:0] r_pred;
    logic               r_pass;
    logic [IDX_W-1:0]   r_idx;
    logic        [16:0] r_frac;
    logic signed [26:0] r_h0;
    logic signed [29:0] r_hp;
    logic               r_neg;
    logic signed [49:0] r_blend;
    logic        [1:0]  r_status;

    // bit-serial multiplier: signed 48-bit times unsigned 17-bit
    logic signed [47:0] r_ma;
    logic signed [48:0] r_mhi;
    logic        [16:0] r_mlo;
    logic        [4:0]  r_mcnt;

    // bit-serial restoring divider: 48-bit by 17-bit, unsigned
    logic [47:0] r_dq;
    logic [16:0] r_drem;
    logic [16:0] r_dd;
    logic [5:0]  r_dcnt;

    logic         r_ovalid;
    logic [116:0] r_odata;
    logic [1:0]   r_ouser;

    // ---------------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------------
    logic signed [65:0] m_prod;
    logic               mul_idle, div_idle;
    logic [47:0]        prod_mag;
    logic signed [44:0] acc_w, grav_f, corr_w;
    logic signed [47:0] vnew, pred_w;
    logic [IDX_W-1:0]   idx_c;
    logic [16:0]        frac_c;
    logic [16:0]        px;
    logic [IDX_W-1:0]   tab_addr;
    logic signed [26:0] tab_q;
    logic signed [28:0] pa_q;
    logic signed [29:0] pa_val;
    logic signed [48:0] quot_s;
    logic signed [48:0] cal_diff;
    logic [48:0]        vabs, gate_f;
    logic accept_in, out_free;

    logic               mul_load, div_load;
    logic signed [47:0] ma_in;
    logic [16:0]        mb_in;
    logic [47:0]        dvd_in;
    logic [16:0]        dvs_in;

    assign m_prod   = {r_mhi, r_mlo};
    assign mul_idle = (r_mcnt == '0);
    assign div_idle = (r_dcnt == '0);
    assign prod_mag = m_prod[65] ? 48'(-m_prod) : m_prod[47:0];

    assign acc_w  = ($signed(m_prod[44:0]) <<< ACC_UP) >>> ACC_DN;
    assign grav_f = $signed({31'd0, r_grav}) <<< FRACTION_BITS;
    assign corr_w = acc_w - grav_f - 45'(r_bias);

    assign vnew   = 48'(baf_pkg::f_sat(64'(r_vel) + 64'($signed(m_prod[65:16])), 48));
    assign pred_w = 48'(baf_pkg::f_sat(64'(r_alt) + 64'($signed(m_prod[65:16])), 48));

    assign px     = r_pass ? r_ground : r_pres;
    assign idx_c  = (r_dq >= 48'(TABLE_ENTRIES - 1)) ? IDX_W'(TABLE_ENTRIES - 1)
                                                      : r_dq[IDX_W-1:0];
    assign frac_c = 17'({1'b0, px} - 18'(int'(idx_c) * TABLE_STEP));

    // one table read place, advancing from the lower to the upper point
    assign tab_addr = (r_state == baf_pkg::ST_PA_H1) ? r_idx + IDX_W'(1) : r_idx;
    assign tab_q    = ALT_TAB[tab_addr];

    assign pa_q   = r_neg ? -$signed({1'b0, r_dq[27:0]}) : $signed({1'b0, r_dq[27:0]});
    assign pa_val = 30'(r_h0) + 30'(pa_q);
    assign quot_s = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});

    assign cal_diff = 49'(r_sum) - $signed({9'd0, r_count, 24'd0} >> 12);

    assign vabs   = r_vel[47] ? 49'(-(49'(r_vel))) : 49'(r_vel);
    assign gate_f = 49'(r_gate) << FRACTION_BITS;

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_ovalid || m_axis_tready;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= baf_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state  = r_state;
        mul_load = 1'b0;
        div_load = 1'b0;
        ma_in    = '0;
        mb_in    = '0;
        dvd_in   = '0;
        dvs_in   = 17'(TABLE_STEP);
        unique case (r_state)
            baf_pkg::ST_IDLE: begin
                if (accept_in) n_state = baf_pkg::ST_DECODE;
            end
            baf_pkg::ST_DECODE: begin
                priority case (r_cmd)
                    baf_pkg::CMD_SAMPLE: n_state = baf_pkg::ST_DONE;
                    baf_pkg::CMD_FINISH: begin
                        if (r_count == '0 || r_count < r_mins) begin
                            n_state = baf_pkg::ST_DONE;
                        end else begin
                            mul_load = 1'b1;
                            ma_in    = cal_diff[47:0];
                            mb_in    = {3'd0, r_grav};
                            n_state  = baf_pkg::ST_CAL_MUL_W;
                        end
                    end
                    baf_pkg::CMD_UPDATE: begin
                        if (!r_aok) begin
                            n_state = baf_pkg::ST_DONE;
                        end else begin
                            mul_load = 1'b1;
                            ma_in    = 48'(r_accel);
                            mb_in    = {3'd0, r_grav};
                            n_state  = baf_pkg::ST_ACC_W;
                        end
                    end
                    default: n_state = baf_pkg::ST_DONE;
                endcase
            end
            baf_pkg::ST_ACC_W: begin
                if (mul_idle) begin
                    mul_load = 1'b1;
                    ma_in    = 48'(corr_w);
                    mb_in    = {1'b0, r_dt};
                    n_state  = baf_pkg::ST_VEL_W;
                end
            end
            baf_pkg::ST_VEL_W: begin
                if (mul_idle) begin
                    mul_load = 1'b1;
                    ma_in    = vnew;
                    mb_in    = {1'b0, r_dt};
                    n_state  = baf_pkg::ST_PRED_W;
                end
            end
            baf_pkg::ST_PRED_W: begin
                if (mul_idle) begin
                    if (r_pok) begin
                        div_load = 1'b1;
                        dvd_in   = 48'(r_pres);
                        n_state  = baf_pkg::ST_PA_DIV_W;
                    end else begin
                        n_state = baf_pkg::ST_GATE;
                    end
                end
            end
            baf_pkg::ST_PA_DIV_W: begin
                if (div_idle) n_state = baf_pkg::ST_PA_H0;
            end
            baf_pkg::ST_PA_H0: n_state = baf_pkg::ST_PA_H1;
            baf_pkg::ST_PA_H1: begin
                mul_load = 1'b1;
                ma_in    = 48'(28'(tab_q) - 28'(r_h0));
                mb_in    = r_frac;
                n_state  = baf_pkg::ST_PA_MUL_W;
            end
            baf_pkg::ST_PA_MUL_W: begin
                if (mul_idle) begin
                    div_load = 1'b1;
                    dvd_in   = prod_mag;
                    n_state  = baf_pkg::ST_PA_Q_W;
                end
            end
            baf_pkg::ST_PA_Q_W: begin
                if (div_idle) begin
                    if (!r_pass) begin
                        div_load = 1'b1;
                        dvd_in   = 48'(r_ground);
                        n_state  = baf_pkg::ST_PA_DIV_W;
                    end else begin
                        mul_load = 1'b1;
                        ma_in    = r_pred;
                        mb_in    = {1'b0, r_wgt};
                        n_state  = baf_pkg::ST_BL_W0;
                    end
                end
            end
            baf_pkg::ST_BL_W0: begin
                if (mul_idle) begin
                    mul_load = 1'b1;
                    ma_in    = 48'(r_baro);
                    mb_in    = 17'(18'd65536 - 18'(r_wgt));
                    n_state  = baf_pkg::ST_BL_W1;
                end
            end
            baf_pkg::ST_BL_W1: begin
                if (mul_idle) n_state = baf_pkg::ST_GATE;
            end
            baf_pkg::ST_GATE: begin
                if (vabs < gate_f) begin
                    mul_load = 1'b1;
                    ma_in    = 48'(r_corr);
                    mb_in    = {1'b0, r_gain};
                    n_state  = baf_pkg::ST_GAIN_W0;
                end else begin
                    n_state = baf_pkg::ST_DONE;
                end
            end
            baf_pkg::ST_GAIN_W0: begin
                if (mul_idle) begin
                    mul_load = 1'b1;
                    ma_in    = 48'($signed(m_prod[60:16]));
                    mb_in    = {1'b0, r_dt};
                    n_state  = baf_pkg::ST_GAIN_W1;
                end
            end
            baf_pkg::ST_GAIN_W1: begin
                if (mul_idle) n_state = baf_pkg::ST_DONE;
            end
            baf_pkg::ST_CAL_MUL_W: begin
                if (mul_idle) begin
                    div_load = 1'b1;
                    dvd_in   = prod_mag;
                    dvs_in   = {1'b0, r_count};
                    n_state  = baf_pkg::ST_CAL_DIV_W;
                end
            end
            baf_pkg::ST_CAL_DIV_W: begin
                if (div_idle) n_state = baf_pkg::ST_DONE;
            end
            baf_pkg::ST_DONE: begin
                if (out_free) n_state = baf_pkg::ST_IDLE;
            end
            default: n_state = baf_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Serial multiplier: add the multiplicand on each set multiplier bit,
    // then shift the partial product right one place
    // ---------------------------------------------------------------------
    logic signed [48:0] mul_sum;
    assign mul_sum = r_mhi + (r_mlo[0] ? 49'(r_ma) : 49'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (mul_load) begin
            r_mcnt <= 5'(baf_pkg::MUL_STEPS);
        end else if (!mul_idle) begin
            r_mcnt <= r_mcnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_load) begin
            r_ma  <= ma_in;
            r_mhi <= '0;
            r_mlo <= mb_in;
        end else if (!mul_idle) begin
            r_mhi <= mul_sum >>> 1;
            r_mlo <= {mul_sum[0], r_mlo[16:1]};
        end
    end

    // ---------------------------------------------------------------------
    // Serial divider: one quotient bit a cycle, restoring
    // ---------------------------------------------------------------------
    logic [17:0] div_shift, div_trial;
    assign div_shift = {r_drem, r_dq[47]};
    assign div_trial = div_shift - {1'b0, r_dd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (div_load) begin
            r_dcnt <= 6'(baf_pkg::DIV_STEPS);
        end else if (!div_idle) begin
            r_dcnt <= r_dcnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_dq   <= dvd_in;
            r_drem <= '0;
            r_dd   <= dvs_in;
        end else if (!div_idle) begin
            if (!div_trial[17]) begin
                r_drem <= div_trial[16:0];
                r_dq   <= {r_dq[46:0], 1'b1};
            end else begin
                r_drem <= div_shift[16:0];
                r_dq   <= {r_dq[46:0], 1'b0};
            end
        end
    end

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ground <= 17'd101325;
            r_grav   <= 14'd9807;
            r_wgt    <= 16'd64225;
            r_gate   <= 20'd500;
            r_gain   <= 16'd655;
            r_mins   <= 16'd100;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                baf_pkg::CFG_GROUND:   r_ground <= i_cfg_data[16:0];
                baf_pkg::CFG_GRAVITY:  r_grav   <= i_cfg_data[13:0];
                baf_pkg::CFG_WEIGHT:   r_wgt    <= i_cfg_data[15:0];
                baf_pkg::CFG_GATE:     r_gate   <= i_cfg_data;
                baf_pkg::CFG_GAIN:     r_gain   <= i_cfg_data[15:0];
                baf_pkg::CFG_MIN_SMPL: r_mins   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input capture and working values
    // ---------------------------------------------------------------------
    assign s_axis_tready = (r_state == baf_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_cmd   <= s_axis_tuser;
            r_accel <= $signed(s_axis_tdata[15:0]);
            r_aok   <= s_axis_tdata[16];
            r_pres  <= s_axis_tdata[33:17];
            r_pok   <= s_axis_tdata[34];
            r_dt    <= s_axis_tdata[50:35];
        end
        unique case (r_state)
            baf_pkg::ST_ACC_W:    if (mul_idle) r_corr <= corr_w;
            baf_pkg::ST_PRED_W: begin
                r_pred <= pred_w;
                r_pass <= 1'b0;
            end
            baf_pkg::ST_PA_DIV_W: begin
                r_idx  <= idx_c;
                r_frac <= frac_c;
            end
            baf_pkg::ST_PA_H0:    r_h0 <= tab_q;
            baf_pkg::ST_PA_MUL_W: r_neg <= m_prod[65];
            baf_pkg::ST_PA_Q_W: begin
                if (div_idle && !r_pass) begin
                    r_hp   <= pa_val;
                    r_pass <= 1'b1;
                end
            end
            baf_pkg::ST_BL_W0:     if (mul_idle) r_blend <= $signed(m_prod[65:16]);
            baf_pkg::ST_CAL_MUL_W: r_neg <= m_prod[65];
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Filter state
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt    <= '0;
            r_vel    <= '0;
            r_bias   <= '0;
            r_baro   <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_status <= baf_pkg::STAT_DONE;
        end else begin
            unique case (r_state)
                baf_pkg::ST_DECODE: begin
                    r_status <= baf_pkg::STAT_DONE;
                    priority case (r_cmd)
                        baf_pkg::CMD_SAMPLE: begin
                            // a full counter drops the sample quietly
                            if (!r_aok) begin
                                r_status <= baf_pkg::STAT_IGNORED;
                            end else if (r_count != 16'hFFFF) begin
                                r_sum   <= r_sum + 48'(r_accel);
                                r_count <= r_count + 16'd1;
                            end
                        end
                        baf_pkg::CMD_FINISH: begin
                            if (r_count == '0 || r_count < r_mins)
                                r_status <= baf_pkg::STAT_FEW;
                        end
                        baf_pkg::CMD_UPDATE: begin
                            if (!r_aok) r_status <= baf_pkg::STAT_IGNORED;
                        end
                        default: r_status <= baf_pkg::STAT_IGNORED;
                    endcase
                end
                baf_pkg::ST_VEL_W: if (mul_idle) r_vel <= vnew;
                baf_pkg::ST_PRED_W: begin
                    // without fresh pressure, propagate only
                    if (mul_idle && !r_pok) r_alt <= pred_w;
                end
                baf_pkg::ST_PA_Q_W: begin
                    if (div_idle && r_pass)
                        r_baro <= 32'(baf_pkg::f_sat(64'(r_hp) - 64'(pa_val), 32));
                end
                baf_pkg::ST_BL_W1: begin
                    if (mul_idle)
                        r_alt <= 48'(baf_pkg::f_sat(64'(r_blend) +
                                 ((64'($signed(m_prod[59:0])) <<< Q_UP) >>> Q_DN), 48));
                end
                baf_pkg::ST_GAIN_W1: begin
                    if (mul_idle)
                        r_bias <= 40'(baf_pkg::f_sat(64'(r_bias) +
                                  64'($signed(m_prod[60:16])), 40));
                end
                baf_pkg::ST_CAL_DIV_W: begin
                    if (div_idle)
                        r_bias <= 40'(baf_pkg::f_sat((64'(quot_s) <<< ACC_UP) >>> ACC_DN, 40));
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Output register: hold the beat until taken
    // ---------------------------------------------------------------------
    logic signed [31:0] alt_o, vel_o;
    logic signed [20:0] bias_o;
    assign alt_o  = 32'(baf_pkg::f_sat(64'(r_alt) >>> FRACTION_BITS, 32));
    assign vel_o  = 32'(baf_pkg::f_sat(64'(r_vel) >>> FRACTION_BITS, 32));
    assign bias_o = 21'(baf_pkg::f_sat(64'(r_bias) >>> FRACTION_BITS, 21));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == baf_pkg::ST_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == baf_pkg::ST_DONE && out_free) begin
            r_odata <= {r_baro, bias_o, vel_o, alt_o};
            r_ouser <= r_status;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'd0, r_odata};
    assign m_axis_tuser  = r_ouser;

endmodule

[src/baf_chk.sv]
// Port checker for the altitude filter, bound to the top level.
// Depends on baf_pkg for the status codes.
module baf_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [55:0]  s_axis_tdata,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [119:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         i_cfg_valid,
    input logic         o_cfg_ready,
    input logic [2:0]   i_cfg_index,
    input logic [19:0]  i_cfg_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result beat changed while stalled");

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == baf_pkg::STAT_DONE ||
                           m_axis_tuser == baf_pkg::STAT_IGNORED ||
                           m_axis_tuser == baf_pkg::STAT_FEW))
        else $error("undefined status code");

    // one item in work: input closes after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // zero fill above the result fields stays clear
    a_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[119:117] == 3'd0))
        else $error("fill bits of result beat set");

endmodule

bind baro_inertial_altitude_filter baf_chk u_baf_chk (.*);

[tb/sv/baro_inertial_altitude_filter_test.sv]
// Self-checking testbench for the barometric/inertial altitude filter.
// Drives directed and random sensor beats plus register writes and checks every result
// beat against a predictor or a typed-in beat. Depends on baf_pkg and the top level.
`timescale 1ns / 1ps

module baro_inertial_altitude_filter_test;
    import baf_pkg::*;

    localparam int  FRAC       = 16;
    localparam int  ENTRIES    = 64;
    localparam int  SEA_PA     = 101325;
    localparam int  STEP       = (PRESSURE_SPAN + ENTRIES - 1) / ENTRIES;
    localparam int  CYCLE_CAP  = 5000000;
    localparam int  DRAIN_WAIT = 400;   // the worst item is an update with pressure

    typedef struct {
        logic signed [31:0] alt;
        logic signed [31:0] vel;
        logic signed [20:0] bias;
        logic signed [31:0] baro;
        logic [1:0]         status;
    } filt_out_t;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [15:0] accel;
        logic               accel_ok;
        logic [16:0]        pres;
        logic               pres_ok;
        logic [15:0]        dt;
        bit                 typed;   // expected beat written out below
        filt_out_t          want;
    } sensor_row_t;

    logic          i_clk = 0;
    logic          i_rst_n = 0;
    logic          s_axis_tvalid = 0;
    logic          s_axis_tready;
    logic [55:0]   s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = CMD_SAMPLE;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 0;
    logic [119:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          i_cfg_valid = 0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = CFG_GROUND;
    logic [19:0]   i_cfg_data = '0;

    baro_inertial_altitude_filter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor state
    longint          alt_pts [0:ENTRIES];
    longint unsigned roots [0:ROOT_COUNT];
    longint unsigned cfg_ground = 101325, cfg_gravity = 9807, cfg_weight = 64225;
    longint unsigned cfg_gate = 500, cfg_gain = 655, cfg_min = 100;
    longint          alt_q, vel_q, bias_q, baro_mm, cal_sum;
    longint unsigned cal_cnt;

    filt_out_t pending_q[$];   // results owed by the filter, oldest first
    int  errors = 0;
    int  results_seen = 0;
    bit  fast_mode = 0;        // no sender gaps, receiver always ready
    longint cycles = 0;

    function automatic longint sat_to(longint x, int bits);
        longint lim;
        lim = 64'sd1 <<< (bits - 1);
        if (x > lim - 1) return lim - 1;
        if (x < -lim) return -lim;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // log2 in Q24 by normalizing and repeated squaring
    function automatic longint log2_fix(longint unsigned p);
        int n, k;
        longint unsigned m;
        longint frac;
        n = 0;
        frac = 0;
        while (n < 31 && (p >> (n + 1)) != 0) n++;
        if (n > 30) n = 30;
        m = (p << (30 - n)) & 64'hFFFF_FFFF;
        for (k = 0; k < 24; k++) begin
            m = (m * m) >> 30;
            frac = frac <<< 1;
            if (m >= (64'd1 << 31)) begin
                m >>= 1;
                frac |= 1;
            end
        end
        return longint'(n) * (64'sd1 <<< 24) + frac;
    endfunction

    // (p / sea level)^0.19 in Q30
    function automatic longint unsigned pressure_ratio_pow(longint unsigned p);
        longint d, e, n;
        longint unsigned f, r;
        int i;
        d = log2_fix(p) - log2_fix(SEA_PA);
        e = (d * EXPONENT_Q30) >>> 30;
        n = e >>> 24;
        f = longint'(e - n * (64'sd1 <<< 24));
        r = 64'd1 << 30;
        for (i = 1; i <= ROOT_COUNT; i++)
            if ((f >> (24 - i)) & 1) r = (r * roots[i]) >> 30;
        if (n > 0) r <<= (n > 4 ? 4 : n);
        else if (n < 0) r = (-n >= 63) ? 0 : (r >> (-n));
        return r;
    endfunction

    function automatic void build_altitude_points();
        int i;
        longint unsigned p;
        roots[0] = 64'd1 << 31;
        roots[1] = int_sqrt(64'd1 << 61);
        for (i = 2; i <= ROOT_COUNT; i++) roots[i] = int_sqrt(roots[i - 1] << 30);
        for (i = 0; i <= ENTRIES; i++) begin
            p = i * STEP;
            if (p == 0) alt_pts[i] = ALT_SCALE_MM;
            else alt_pts[i] = ALT_SCALE_MM
                - longint'((longint'(ALT_SCALE_MM) * pressure_ratio_pow(p)) >> 30);
        end
    endfunction

    function automatic longint altitude_of(longint unsigned p);
        longint i, f, h0, h1;
        i = p / STEP;
        if (i >= ENTRIES) i = ENTRIES - 1;
        f = longint'(p) - i * STEP;
        h0 = alt_pts[i];
        h1 = alt_pts[i + 1];
        return h0 + (h1 - h0) * f / STEP;   // truncates toward zero
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [19:0] val);
        case (idx)
            CFG_GROUND:   cfg_ground  = val[16:0];
            CFG_GRAVITY:  cfg_gravity = val[13:0];
            CFG_WEIGHT:   cfg_weight  = val[15:0];
            CFG_GATE:     cfg_gate    = val[19:0];
            CFG_GAIN:     cfg_gain    = val[15:0];
            CFG_MIN_SMPL: cfg_min     = val[15:0];
            default: ;
        endcase
    endfunction

    // advance the filter state by one sensor beat and return the reported beat
    function automatic filt_out_t filter_step(sensor_row_t r);
        longint one, a, dt, acc, corr, vmag, baro, pred, w, diff, q, g;
        filt_out_t o;
        one = 64'sd1 <<< FRAC;
        a = r.accel;
        dt = r.dt;
        g = cfg_gravity;
        o.status = STAT_DONE;
        case (r.cmd)
            CMD_SAMPLE: begin
                if (!r.accel_ok) o.status = STAT_IGNORED;
                else if (cal_cnt < 65535) begin
                    cal_sum += a;
                    cal_cnt++;
                end
            end
            CMD_FINISH: begin
                if (cal_cnt == 0 || cal_cnt < cfg_min) o.status = STAT_FEW;
                else begin
                    diff = cal_sum - 4096 * longint'(cal_cnt);
                    q = diff * g / longint'(cal_cnt);
                    bias_q = sat_to((q * one) >>> ONE_G_SHIFT, 40);
                end
            end
            CMD_UPDATE: begin
                if (!r.accel_ok) o.status = STAT_IGNORED;
                else begin
                    acc = (a * g * one) >>> ONE_G_SHIFT;
                    corr = acc - g * one - bias_q;
                    vel_q = sat_to(vel_q + ((corr * dt) >>> 16), 48);
                    if (r.pres_ok) begin
                        baro = altitude_of(r.pres) - altitude_of(cfg_ground);
                        w = cfg_weight;
                        baro_mm = sat_to(baro, 32);
                        pred = sat_to(alt_q + ((vel_q * dt) >>> 16), 48);
                        alt_q = sat_to(((w * pred) >>> 16) + (65536 - w) * baro_mm, 48);
                    end else begin
                        alt_q = sat_to(alt_q + ((vel_q * dt) >>> 16), 48);
                    end
                    vmag = vel_q < 0 ? -vel_q : vel_q;
                    if (vmag < longint'(cfg_gate) * one)
                        bias_q = sat_to(bias_q
                            + ((((corr * longint'(cfg_gain)) >>> 16) * dt) >>> 16), 40);
                end
            end
            default: o.status = STAT_IGNORED;
        endcase
        o.alt  = sat_to(alt_q >>> FRAC, 32);
        o.vel  = sat_to(vel_q >>> FRAC, 32);
        o.bias = sat_to(bias_q >>> FRAC, 21);
        o.baro = baro_mm;
        return o;
    endfunction

    // ---------------------------------------------------------------- timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receiver
    int rx_mode = 0, rx_left = 0, hold_left = 0;
    bit long_hold_done = 0;

    always @(posedge i_clk) begin
        if (!long_hold_done && results_seen == 300) begin
            // hold off long enough for the filter to back up into its input
            long_hold_done <= 1;
            hold_left <= 3000;
            m_axis_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 0;
        end else if (fast_mode) begin
            m_axis_tready <= 1;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(50, 400);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                0: m_axis_tready <= 1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                2: m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------- result checker
    always @(posedge i_clk) begin
        filt_out_t w, g;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            g.alt    = m_axis_tdata[31:0];
            g.vel    = m_axis_tdata[63:32];
            g.bias   = m_axis_tdata[84:64];
            g.baro   = m_axis_tdata[116:85];
            g.status = m_axis_tuser;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors < 40) $display("%0t: result beat with none owed", $time);
            end else begin
                w = pending_q.pop_front();
                if (g.alt != w.alt || g.vel != w.vel || g.bias != w.bias
                        || g.baro != w.baro || g.status != w.status
                        || m_axis_tdata[119:117] != 0) begin
                    errors++;
                    if (errors < 40)
                        $display("%0t: mismatch exp alt %0d vel %0d bias %0d baro %0d st %0d",
                                 $time, w.alt, w.vel, w.bias, w.baro, w.status,
                                 " got alt %0d vel %0d bias %0d baro %0d st %0d",
                                 g.alt, g.vel, g.bias, g.baro, g.status);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sender
    int burst_left = 0;

    task automatic send_beat(sensor_row_t r);
        filt_out_t o;
        if (!fast_mode && burst_left == 0) begin
            // drop valid for a random gap, then start a new burst
            s_axis_tvalid <= 0;
            repeat ($urandom_range(0, 12)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {5'd0, r.dt, r.pres_ok, r.pres, r.accel_ok, r.accel};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        o = filter_step(r);
        pending_q.push_back(r.typed ? r.want : o);
    endtask

    task automatic end_beats();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    task automatic write_all(logic [19:0] gp, logic [19:0] gr, logic [19:0] wt,
                             logic [19:0] gt, logic [19:0] gn, logic [19:0] mn);
        write_reg(CFG_GROUND, gp);
        write_reg(CFG_GRAVITY, gr);
        write_reg(CFG_WEIGHT, wt);
        write_reg(CFG_GATE, gt);
        write_reg(CFG_GAIN, gn);
        write_reg(CFG_MIN_SMPL, mn);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    // wait out every owed beat, then the longest item latency
    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic sensor_row_t row(logic [1:0] c, int a, bit aok, int p, bit pok, int dt);
        sensor_row_t r;
        r.cmd = c; r.accel = a; r.accel_ok = aok; r.pres = p; r.pres_ok = pok; r.dt = dt;
        r.typed = 0;
        r.want = '{default: 0};
        return r;
    endfunction

    function automatic sensor_row_t zero_row(logic [1:0] c, bit aok, logic [1:0] st);
        sensor_row_t r;
        r = row(c, 4096, aok, 90000, 1, 655);
        r.typed = 1;
        r.want.status = st;
        return r;
    endfunction

    // well-formed flight: mostly valid updates, a few samples and finishes, some noise
    function automatic sensor_row_t random_row();
        sensor_row_t r;
        int k;
        k = $urandom_range(0, 99);
        r = row(CMD_UPDATE, 0, 1, 0, 0, 0);
        if (k < 12) r.cmd = CMD_SAMPLE;
        else if (k < 15) r.cmd = CMD_FINISH;
        else if (k < 17) r.cmd = 2'd3;
        r.accel = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                              : 4096 + $urandom_range(0, 800) - 400;
        r.accel_ok = ($urandom_range(0, 15) != 0);
        r.pres = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                             : $urandom_range(95000, 102000);
        r.pres_ok = ($urandom_range(0, 2) != 0);
        r.dt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(100, 1000);
        return r;
    endfunction

    // ---------------------------------------------------------------- main sequence
    sensor_row_t directed [$];

    initial begin
        int ph, i;
        build_altitude_points();
        alt_q = 0; vel_q = 0; bias_q = 0; baro_mm = 0; cal_sum = 0; cal_cnt = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // after reset every output is zero; these beats leave it so
        directed.push_back(zero_row(2'd3, 1, STAT_IGNORED));
        directed.push_back(zero_row(CMD_FINISH, 1, STAT_FEW));
        directed.push_back(zero_row(CMD_SAMPLE, 0, STAT_IGNORED));
        directed.push_back(zero_row(CMD_UPDATE, 0, STAT_IGNORED));
        directed.push_back(row(CMD_SAMPLE, -32768, 1, 0, 0, 0));
        directed.push_back(row(CMD_SAMPLE, 32767, 1, 131071, 1, 65535));
        directed.push_back(row(CMD_SAMPLE, 4096, 1, 0, 0, 0));
        directed.push_back(row(CMD_FINISH, 0, 0, 0, 0, 0));
        directed.push_back(row(CMD_UPDATE, 4096, 1, 0, 0, 0));
        directed.push_back(row(CMD_UPDATE, 4096, 1, 0, 1, 655));
        directed.push_back(row(CMD_UPDATE, 4096, 1, 131071, 1, 655));
        directed.push_back(row(CMD_UPDATE, 4096, 1, 101325, 1, 65535));
        directed.push_back(row(CMD_UPDATE, 32767, 1, 100000, 0, 65535));
        directed.push_back(row(CMD_UPDATE, -32768, 1, 99000, 1, 65535));
        directed.push_back(row(CMD_UPDATE, 4100, 1, 101000, 1, 1));
        directed.push_back(row(CMD_UPDATE, 0, 1, 2047, 1, 300));
        directed.push_back(row(CMD_UPDATE, 4096, 1, 2048, 1, 300));
        directed.push_back(row(2'd3, -1, 0, 131071, 1, 65535));
        foreach (directed[i]) send_beat(directed[i]);
        end_beats();
        drain();

        // register sets: defaults with a zero sample minimum, both extremes, then random ones
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_all(101325, 9807, 64225, 500, 655, 0);
                1: write_all(0, 16383, 0, 1000000, 65535, 0);
                2: write_all(131071, 0, 65535, 0, 0, 65535);
                default: write_all($urandom_range(0, 131071), $urandom_range(0, 16383),
                                   $urandom_range(0, 65535), $urandom_range(0, 1000000),
                                   $urandom_range(0, 65535), $urandom_range(0, 200));
            endcase
            for (i = 0; i < 360; i++) send_beat(random_row());
            end_beats();
            drain();
        end

        // fill the calibration counter past its top, then finish on the saturated count
        fast_mode = 1;
        write_all(101325, 9807, 64225, 500, 655, 100);
        for (i = 0; i < 65540; i++)
            send_beat(row(CMD_SAMPLE, 4096 + $urandom_range(0, 200) - 100, 1, 0, 0, 0));
        send_beat(row(CMD_FINISH, 0, 1, 0, 0, 0));
        send_beat(row(CMD_UPDATE, 4096, 1, 101325, 1, 655));
        end_beats();
        fast_mode = 0;
        drain();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
